// ===== src/ake_pkg.sv =====
// ----------------------------------------------------------------------------
// ake_pkg
// Shared types, constants and helper functions for the AES key expansion.
// ----------------------------------------------------------------------------
`default_nettype none

package ake_pkg;

  // Key size codes held in the key_length register
  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2
  } key_len_e;

  localparam int unsigned WordW  = 32;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned HistN  = 8;   // words kept in the history window
  localparam logic [7:0]  GfPoly = 8'h1b;

  // Input request: the cipher key as four 64-bit parts
  typedef struct packed {
    logic [63:0] key_part_0;
    logic [63:0] key_part_1;
    logic [63:0] key_part_2;
    logic [63:0] key_part_3;
  } key_t;

  // One result: a schedule word with its position
  typedef struct packed {
    logic [WordW-1:0] schedule_word;
    logic [IdxW-1:0]  word_index;
    logic             last;
  } result_t;

  // Controller to datapath command
  typedef struct packed {
    logic            load;      // take a new key into the window
    logic            step;      // produce one schedule word
    logic            key_word;  // word comes straight from the key
    logic            do_rot;    // RotWord, SubWord and Rcon
    logic            do_sub;    // SubWord only (256-bit keys)
    key_len_e        klen;
    logic [IdxW-1:0] word_index;
    logic            last;
  } ctrl_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  // S-box on each byte of a word
  function automatic logic [WordW-1:0] sub_word(input logic [WordW-1:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Rotate left by one byte
  function automatic logic [WordW-1:0] rot_word(input logic [WordW-1:0] w);
    rot_word = {w[23:0], w[31:24]};
  endfunction

  // GF(2^8) doubling
  function automatic logic [7:0] gf_double(input logic [7:0] b);
    gf_double = {b[6:0], 1'b0} ^ (b[7] ? GfPoly : 8'h00);
  endfunction

  // Nk - 1 for the key size
  function automatic logic [2:0] nk_m1(input key_len_e klen);
    case (klen)
      KEY_128: nk_m1 = 3'd3;
      KEY_192: nk_m1 = 3'd5;
      default: nk_m1 = 3'd7;
    endcase
  endfunction

  // Index of the final schedule word
  function automatic logic [IdxW-1:0] last_index(input key_len_e klen);
    case (klen)
      KEY_128: last_index = 6'd43;
      KEY_192: last_index = 6'd51;
      default: last_index = 6'd59;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== src/ake_ctrl.sv =====
// ----------------------------------------------------------------------------
// ake_ctrl
// Controller: key length register, word counter and sequencing commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ake_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               key_length_we_i,
  input  wire logic [1:0]         key_length_i,
  output ake_pkg::ctrl_cmd_t      cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StRun  = 1'b1;

  logic                       state_q, state_d;
  logic [ake_pkg::IdxW-1:0]   count_q, count_d;
  logic [2:0]                 mod_q, mod_d;
  ake_pkg::key_len_e          klen_q;
  logic [2:0]                 nk_last;
  logic                       accept;
  logic                       key_word;
  logic                       last_word;

  assign accept    = start && (state_q == StIdle);
  assign busy      = (state_q == StRun);
  assign nk_last   = ake_pkg::nk_m1(klen_q);
  assign key_word  = (count_q <= {3'b000, nk_last});
  assign last_word = (count_q == ake_pkg::last_index(klen_q));

  // Key length register; code 3 behaves as a 256-bit key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q <= ake_pkg::KEY_256;
    end else if (key_length_we_i) begin
      klen_q <= (key_length_i == 2'd3) ? ake_pkg::KEY_256
                                       : ake_pkg::key_len_e'(key_length_i);
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    mod_d   = mod_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StRun;
          count_d = '0;
          mod_d   = '0;
        end
      end
      StRun: begin
        count_d = count_q + 6'd1;
        mod_d   = (mod_q == nk_last) ? 3'd0 : mod_q + 3'd1;
        if (last_word) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      mod_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      mod_q   <= mod_d;
    end
  end

  // Commands to the datapath
  always_comb begin
    cmd_o.load       = accept;
    cmd_o.step       = busy;
    cmd_o.key_word   = key_word;
    cmd_o.do_rot     = !key_word && (mod_q == 3'd0);
    cmd_o.do_sub     = !key_word && (klen_q == ake_pkg::KEY_256) && (mod_q == 3'd4);
    cmd_o.klen       = klen_q;
    cmd_o.word_index = count_q;
    cmd_o.last       = last_word;
  end

  // Assertions
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> count_q <= ake_pkg::last_index(klen_q))
    else $error("word counter past end of schedule");

  a_start_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && count_q == 6'd0 && mod_q == 3'd0)
    else $error("request did not start a fresh schedule");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && last_word) |=> !busy)
    else $error("busy held after final word");

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> mod_q <= nk_last)
    else $error("word phase out of range");

endmodule

`default_nettype wire

// ===== src/ake_datapath.sv =====
// ----------------------------------------------------------------------------
// ake_datapath
// Datapath: eight-word history window, Rcon register, word transform and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ake_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ake_pkg::ctrl_cmd_t cmd_i,
  input  wire ake_pkg::key_t      key_i,
  output ake_pkg::result_t        result_o,
  output logic                    result_strobe_o
);

  // hist_q[i] holds the word i+1 places before the one being produced
  logic [ake_pkg::WordW-1:0] hist_q [ake_pkg::HistN];
  logic [ake_pkg::WordW-1:0] hist_d [ake_pkg::HistN];
  logic [ake_pkg::WordW-1:0] kw     [ake_pkg::HistN];
  logic [7:0]                rcon_q;
  logic [2:0]                nk_last;
  logic [ake_pkg::WordW-1:0] tap;
  logic [ake_pkg::WordW-1:0] xform;
  logic [ake_pkg::WordW-1:0] new_word;
  ake_pkg::result_t          result_q;
  logic                      strobe_q;

  assign nk_last = ake_pkg::nk_m1(cmd_i.klen);

  // Key words in order
  assign kw[0] = key_i.key_part_0[63:32];
  assign kw[1] = key_i.key_part_0[31:0];
  assign kw[2] = key_i.key_part_1[63:32];
  assign kw[3] = key_i.key_part_1[31:0];
  assign kw[4] = key_i.key_part_2[63:32];
  assign kw[5] = key_i.key_part_2[31:0];
  assign kw[6] = key_i.key_part_3[63:32];
  assign kw[7] = key_i.key_part_3[31:0];

  // Word Nk back
  assign tap = hist_q[nk_last];

  // Transform of the previous word
  always_comb begin
    if (cmd_i.do_rot) begin
      xform = ake_pkg::sub_word(ake_pkg::rot_word(hist_q[0])) ^ {rcon_q, 24'h000000};
    end else if (cmd_i.do_sub) begin
      xform = ake_pkg::sub_word(hist_q[0]);
    end else begin
      xform = hist_q[0];
    end
  end

  // Key words pass through: the window is preloaded so the tap walks the key
  assign new_word = cmd_i.key_word ? tap : (xform ^ tap);

  // Window load or shift
  always_comb begin
    for (int i = 0; i < ake_pkg::HistN; i++) begin
      hist_d[i] = hist_q[i];
    end
    if (cmd_i.load) begin
      for (int i = 0; i < ake_pkg::HistN; i++) begin
        hist_d[i] = kw[nk_last - 3'(i)];
      end
    end else if (cmd_i.step) begin
      hist_d[0] = new_word;
      for (int i = 1; i < ake_pkg::HistN; i++) begin
        hist_d[i] = hist_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ake_pkg::HistN; i++) begin
      hist_q[i] <= hist_d[i];
    end
  end

  // Rcon sequence
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rcon_q <= 8'h01;
    end else if (cmd_i.step && cmd_i.do_rot) begin
      rcon_q <= ake_pkg::gf_double(rcon_q);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      result_q.schedule_word <= new_word;
      result_q.word_index    <= cmd_i.word_index;
      result_q.last          <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.step;
    end
  end

  assign result_o        = result_q;
  assign result_strobe_o = strobe_q;

  // Assertions
  a_index_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && !result_q.last && cmd_i.step) |->
      cmd_i.word_index == result_q.word_index + 6'd1)
    else $error("schedule words out of order");

  a_no_load_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !cmd_i.load)
    else $error("key loaded while a schedule is running");

  a_rot_not_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> !(cmd_i.do_rot && cmd_i.do_sub))
    else $error("conflicting transforms");

endmodule

`default_nettype wire

// ===== src/aes_key_expansion.sv =====
// ----------------------------------------------------------------------------
// aes_key_expansion
// AES key schedule generator: one key in, 44/52/60 round-key words out.
// ----------------------------------------------------------------------------
// Timing: start is registered into the controller's run state, then the result
//   register strobes the first word; after that one word per cycle, each word
//   needing the one before it from the window. A new key is taken only when idle.
// busy is high while words are produced; the receiver cannot stall.
// Reset: asynchronous active-low; key_length returns to 256 bits, block idles.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_key_expansion (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire ake_pkg::key_t  key_i,
  input  wire logic           key_length_we_i,
  input  wire logic [1:0]     key_length_i,
  output ake_pkg::result_t    result_o,
  output logic                result_strobe_o
);

  ake_pkg::ctrl_cmd_t cmd;

  // Sequencing
  ake_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .key_length_we_i (key_length_we_i),
    .key_length_i    (key_length_i),
    .cmd_o           (cmd)
  );

  // Word generation
  ake_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .key_i           (key_i),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

endmodule

`default_nettype wire
